>>> sv/fdtd_mur_pkg.sv
// Shared types, codes and fixed-point helpers for the 1-D FDTD field update unit.
package fdtd_mur_pkg;

    localparam int NUM_CELLS_DEF = 256;
    localparam int FIELD_W       = 16;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_SOURCE_CELL     = 2'd0,
        REG_BOUNDARY_FACTOR = 2'd1,
        REG_ELECTRIC_COEFF  = 2'd2,
        REG_MAGNETIC_COEFF  = 2'd3
    } reg_idx_t;

    localparam logic [7:0]         SOURCE_CELL_RST     = 8'd128;
    localparam logic signed [14:0] BOUNDARY_FACTOR_RST = 15'sd5461;
    localparam logic [13:0]        ELECTRIC_COEFF_RST  = 14'd8192;
    localparam logic [13:0]        MAGNETIC_COEFF_RST  = 14'd8192;

    typedef struct packed {
        logic [1:0]          op;
        logic signed [15:0]  source_value;
        logic [7:0]          cell_index;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0]  ex_value;
        logic signed [15:0]  hy_value;
    } result_t;

    // Q.26 product to Q.12: add half an LSB, floor-shift by 14
    function automatic logic signed [18:0] round14(input logic signed [31:0] prod);
        logic signed [32:0] sum;
        sum = {prod[31], prod} + 33'sd8192;
        return sum[32:14];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] res;
        if (v > 21'sd32767)
            res = 16'sh7fff;
        else if (v < -21'sd32768)
            res = 16'sh8000;
        else
            res = v[15:0];
        return res;
    endfunction

    function automatic logic signed [20:0] sx16(input logic signed [15:0] v);
        return {{5{v[15]}}, v};
    endfunction

    function automatic logic signed [20:0] sx19(input logic signed [18:0] v);
        return {{2{v[18]}}, v};
    endfunction

endpackage

>>> sv/fdtd_mur_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdtd_mur_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/fdtd_1d_mur_field_update_unit.sv
// Top level: 1-D FDTD field update with first-order Mur boundaries, one shared multiplier.
// Step: an E sweep, the Mur edge updates (multiply, then write, at the low edge and then the
// high edge) and an H sweep, one cell per cycle through a three-stage multiply pipeline
// with a drain after each sweep, then the read-back. Read (op 1 or 3): read-back only. Clear:
// zero both field RAMs, then the read-back. One item at a time; busy is high throughout. After
// reset the field RAMs are swept to zero with busy high; register writes are taken meanwhile.
module fdtd_1d_mur_field_update_unit #(
    parameter int NUM_CELLS = fdtd_mur_pkg::NUM_CELLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  fdtd_mur_pkg::cmd_t    cmd,
    output logic                  done,
    output fdtd_mur_pkg::result_t result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(NUM_CELLS);
    localparam logic [AW-1:0] IDX_FIRST = AW'(0);
    localparam logic [AW-1:0] IDX_ONE   = AW'(1);
    localparam logic [AW-1:0] IDX_LAST  = AW'(NUM_CELLS - 1);
    localparam logic [AW-1:0] IDX_PREV  = AW'(NUM_CELLS - 2);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E_SWEEP,
        ST_E_DRAIN,
        ST_MUR_LO_MUL,
        ST_MUR_LO_WR,
        ST_MUR_HI_MUL,
        ST_MUR_HI_WR,
        ST_H_SWEEP,
        ST_H_DRAIN,
        ST_READ,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] cnt_reg;
    logic          clr_reply_reg;
    logic          a_vld_reg;
    logic          b_vld_reg;
    logic          c_vld_reg;
    logic          done_reg;
    fdtd_mur_pkg::result_t result_reg;
    logic signed [15:0] low_edge_reg;
    logic signed [15:0] high_edge_reg;

    logic [7:0]         source_cell_reg;
    logic signed [14:0] boundary_factor_reg;
    logic [13:0]        electric_coeff_reg;
    logic [13:0]        magnetic_coeff_reg;

    // payload
    fdtd_mur_pkg::cmd_t cmd_reg;
    logic [AW-1:0]      a_idx_reg;
    logic [AW-1:0]      b_idx_reg;
    logic [AW-1:0]      c_idx_reg;
    logic signed [16:0] b_diff_reg;
    logic signed [15:0] b_base_reg;
    logic signed [15:0] c_base_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] h_prev_reg;
    logic signed [15:0] e_prev_reg;
    logic signed [15:0] old_lo_reg;
    logic signed [15:0] old_hi_reg;
    logic signed [15:0] e1_new_reg;
    logic signed [15:0] en2_new_reg;

    logic               accept;
    logic               e_phase;
    logic               sweeping;
    logic               pipe_empty;
    logic signed [15:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [32:0] mul_full;
    logic signed [15:0] sum_next;
    logic signed [15:0] upd_next;
    logic signed [15:0] mur_next;
    logic               is_src;
    logic               idx_ok;

    logic               e_we;
    logic [AW-1:0]      e_waddr;
    logic signed [15:0] e_wdata;
    logic [AW-1:0]      raddr;
    logic signed [15:0] e_rdata;
    logic               h_we;
    logic [AW-1:0]      h_waddr;
    logic signed [15:0] h_wdata;
    logic signed [15:0] h_rdata;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign result   = result_reg;
    assign pready   = 1'b1;
    assign e_phase  = (state_reg == ST_E_SWEEP) || (state_reg == ST_E_DRAIN);
    assign sweeping = (state_reg == ST_E_SWEEP) || (state_reg == ST_H_SWEEP);
    assign pipe_empty = !a_vld_reg && !b_vld_reg && !c_vld_reg;
    assign idx_ok   = (32'(cmd_reg.cell_index) < 32'(NUM_CELLS));

    // Shared multiplier: sweep coefficient or Mur factor against a 17-bit difference
    always_comb
    begin
        case (state_reg)
            ST_MUR_LO_MUL:
            begin
                mul_a = {boundary_factor_reg[14], boundary_factor_reg};
                mul_b = {e1_new_reg[15], e1_new_reg} - {old_lo_reg[15], old_lo_reg};
            end
            ST_MUR_HI_MUL:
            begin
                mul_a = {boundary_factor_reg[14], boundary_factor_reg};
                mul_b = {en2_new_reg[15], en2_new_reg} - {old_hi_reg[15], old_hi_reg};
            end
            ST_H_SWEEP, ST_H_DRAIN:
            begin
                mul_a = {2'b00, magnetic_coeff_reg};
                mul_b = b_diff_reg;
            end
            default:
            begin
                mul_a = {2'b00, electric_coeff_reg};
                mul_b = b_diff_reg;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    always_comb
    begin
        sum_next = fdtd_mur_pkg::sat16(fdtd_mur_pkg::sx16(c_base_reg)
                   + fdtd_mur_pkg::sx19(fdtd_mur_pkg::round14(prod_reg)));
        is_src   = e_phase && (32'(c_idx_reg) == 32'(source_cell_reg));
        upd_next = is_src ? fdtd_mur_pkg::sat16(fdtd_mur_pkg::sx16(sum_next)
                   + fdtd_mur_pkg::sx16(cmd_reg.source_value)) : sum_next;
        mur_next = fdtd_mur_pkg::sat16(
                   fdtd_mur_pkg::sx16((state_reg == ST_MUR_LO_WR) ? low_edge_reg : high_edge_reg)
                   - fdtd_mur_pkg::sx19(fdtd_mur_pkg::round14(prod_reg)));
    end

    // RAM port steering
    always_comb
    begin
        raddr   = (state_reg == ST_READ) ? AW'(cmd_reg.cell_index) : cnt_reg;
        e_we    = 1'b0;
        e_waddr = c_idx_reg;
        e_wdata = upd_next;
        h_we    = 1'b0;
        h_waddr = c_idx_reg;
        h_wdata = upd_next;
        case (state_reg)
            ST_CLEAR:
            begin
                e_we    = 1'b1;
                e_waddr = cnt_reg;
                e_wdata = '0;
                h_we    = 1'b1;
                h_waddr = cnt_reg;
                h_wdata = '0;
            end
            ST_MUR_LO_WR:
            begin
                e_we    = 1'b1;
                e_waddr = IDX_FIRST;
                e_wdata = mur_next;
            end
            ST_MUR_HI_WR:
            begin
                e_we    = 1'b1;
                e_waddr = IDX_LAST;
                e_wdata = mur_next;
            end
            ST_E_SWEEP, ST_E_DRAIN:
            begin
                e_we = c_vld_reg;
            end
            ST_H_SWEEP, ST_H_DRAIN:
            begin
                h_we = c_vld_reg;
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    fdtd_mur_ram #(
        .WIDTH (fdtd_mur_pkg::FIELD_W),
        .DEPTH (NUM_CELLS)
    ) u_e_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (raddr),
        .rdata (e_rdata)
    );

    fdtd_mur_ram #(
        .WIDTH (fdtd_mur_pkg::FIELD_W),
        .DEPTH (NUM_CELLS)
    ) u_h_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (raddr),
        .rdata (h_rdata)
    );

    // Sequencer, pipeline valids, edge memories and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reply_reg <= 1'b0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
            low_edge_reg  <= '0;
            high_edge_reg <= '0;
        end
        else
        begin
            done_reg  <= 1'b0;
            a_vld_reg <= sweeping;
            b_vld_reg <= a_vld_reg && (e_phase ? (a_idx_reg != IDX_FIRST && a_idx_reg != IDX_LAST)
                                               : (a_idx_reg != IDX_FIRST));
            c_vld_reg <= b_vld_reg;
            case (state_reg)
                ST_CLEAR:
                begin
                    low_edge_reg  <= '0;
                    high_edge_reg <= '0;
                    cnt_reg       <= cnt_reg + IDX_ONE;
                    if (cnt_reg == IDX_LAST)
                    begin
                        cnt_reg       <= '0;
                        clr_reply_reg <= 1'b0;
                        state_reg     <= clr_reply_reg ? ST_READ : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        case (fdtd_mur_pkg::op_t'(cmd.op))
                            fdtd_mur_pkg::OP_STEP:
                            begin
                                state_reg <= ST_E_SWEEP;
                            end
                            fdtd_mur_pkg::OP_CLEAR:
                            begin
                                clr_reply_reg <= 1'b1;
                                state_reg     <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_READ;
                            end
                        endcase
                    end
                end
                ST_E_SWEEP, ST_H_SWEEP:
                begin
                    cnt_reg <= cnt_reg + IDX_ONE;
                    if (cnt_reg == IDX_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == ST_E_SWEEP) ? ST_E_DRAIN : ST_H_DRAIN;
                    end
                end
                ST_E_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        state_reg <= ST_MUR_LO_MUL;
                    end
                end
                ST_MUR_LO_MUL:
                begin
                    state_reg <= ST_MUR_LO_WR;
                end
                ST_MUR_LO_WR:
                begin
                    low_edge_reg <= e1_new_reg;
                    state_reg    <= ST_MUR_HI_MUL;
                end
                ST_MUR_HI_MUL:
                begin
                    state_reg <= ST_MUR_HI_WR;
                end
                ST_MUR_HI_WR:
                begin
                    high_edge_reg <= en2_new_reg;
                    state_reg     <= ST_H_SWEEP;
                end
                ST_H_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    done_reg            <= 1'b1;
                    result_reg.ex_value <= idx_ok ? e_rdata : '0;
                    result_reg.hy_value <= idx_ok ? h_rdata : '0;
                    state_reg           <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: read-back stage, multiply stage, update stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        a_idx_reg <= cnt_reg;
        prod_reg  <= mul_full[31:0];
        c_base_reg <= b_base_reg;
        c_idx_reg  <= b_idx_reg;
        if (a_vld_reg)
        begin
            h_prev_reg <= h_rdata;
            e_prev_reg <= e_rdata;
            if (e_phase)
            begin
                // hold the edge values from before the step for Mur
                if (a_idx_reg == IDX_FIRST)
                begin
                    old_lo_reg <= e_rdata;
                end
                if (a_idx_reg == IDX_LAST)
                begin
                    old_hi_reg <= e_rdata;
                end
                b_diff_reg <= {h_prev_reg[15], h_prev_reg} - {h_rdata[15], h_rdata};
                b_base_reg <= e_rdata;
                b_idx_reg  <= a_idx_reg;
            end
            else
            begin
                b_diff_reg <= {e_prev_reg[15], e_prev_reg} - {e_rdata[15], e_rdata};
                b_base_reg <= h_prev_reg;
                b_idx_reg  <= a_idx_reg - IDX_ONE;
            end
        end
        if (c_vld_reg && e_phase)
        begin
            if (c_idx_reg == IDX_ONE)
            begin
                e1_new_reg <= upd_next;
            end
            if (c_idx_reg == IDX_PREV)
            begin
                en2_new_reg <= upd_next;
            end
        end
    end

    // Register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_cell_reg     <= fdtd_mur_pkg::SOURCE_CELL_RST;
            boundary_factor_reg <= fdtd_mur_pkg::BOUNDARY_FACTOR_RST;
            electric_coeff_reg  <= fdtd_mur_pkg::ELECTRIC_COEFF_RST;
            magnetic_coeff_reg  <= fdtd_mur_pkg::MAGNETIC_COEFF_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (fdtd_mur_pkg::reg_idx_t'(paddr[3:2]))
                fdtd_mur_pkg::REG_SOURCE_CELL:     source_cell_reg     <= pwdata[7:0];
                fdtd_mur_pkg::REG_BOUNDARY_FACTOR: boundary_factor_reg <= pwdata[14:0];
                fdtd_mur_pkg::REG_ELECTRIC_COEFF:  electric_coeff_reg  <= pwdata[13:0];
                fdtd_mur_pkg::REG_MAGNETIC_COEFF:  magnetic_coeff_reg  <= pwdata[13:0];
                default:                           source_cell_reg     <= source_cell_reg;
            endcase
        end
    end

    always_comb
    begin
        case (fdtd_mur_pkg::reg_idx_t'(paddr[3:2]))
            fdtd_mur_pkg::REG_SOURCE_CELL:     prdata = {24'd0, source_cell_reg};
            fdtd_mur_pkg::REG_BOUNDARY_FACTOR: prdata = {{17{boundary_factor_reg[14]}},
                                                         boundary_factor_reg};
            fdtd_mur_pkg::REG_ELECTRIC_COEFF:  prdata = {18'd0, electric_coeff_reg};
            fdtd_mur_pkg::REG_MAGNETIC_COEFF:  prdata = {18'd0, magnetic_coeff_reg};
            default:                           prdata = '0;
        endcase
    end

endmodule
